[design/sorted_insert_table_core_defines.svh]
// assertion macros for the sorted insert table
`ifndef SORTED_INSERT_TABLE_CORE_DEFINES_SVH
`define SORTED_INSERT_TABLE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SIT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sit_pkg.sv]
// shared types and codes of the sorted insert table
package sit_pkg;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LIST   = 1'b1;

	localparam logic [1:0] STATUS_INSERTED = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_ENTRY    = 2'd2;
	localparam logic [1:0] STATUS_EMPTY    = 2'd3;

	// broadcast to every cell of the row
	typedef struct packed {
		logic insert;
		logic rotate;
	} cell_ctrl_t;

	// one result word
	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  rating;
		logic [15:0] tag;
		logic        last;
	} res_t;

endpackage

[design/sorted_insert_table_core.sv]
// top level of the sorted insert table: cell row, list sequencer, output buffer
//
// Keeps up to TABLE_DEPTH records in ascending rating order in a row of cells.
// When an insert word (tuser 0) is taken, every cell compares its rating with
// the new one and either holds, takes its left neighbour, or takes the new
// record, so the new record lands ahead of stored records of equal rating; one
// status word (inserted, or table full and dropped) follows. A list word
// (tuser 1) gives one word per stored record, in order, with tlast on the final
// one; the row rotates one place a cycle towards cell 0 while the output buffer
// has room, so a list occupies the block until its last record is sent and no
// input is taken meanwhile. An empty table answers a list with one empty status
// word. Results pass through a two-word output buffer, so an input word can be
// taken while one result still waits downstream. Tags wider than TAG_WIDTH keep
// their low bits; the output tag is the low 16 bits of the stored one. No
// clearing pass after reset: only entries below the fill count are ever read.
module sorted_insert_table_core import sit_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int TAG_WIDTH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // new_rating [3:0], record_tag [19:4], zero [23:20]
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // out_rating [3:0], out_tag [19:4], zero [23:20]
	output logic [1:0]  m_tuser,  // status
	output logic        m_tlast
);

`include "sorted_insert_table_core_defines.svh"

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// sequencer states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LIST = 1'b1;

	logic          state_q;
	logic [CW-1:0] cnt_q;      // fill count of the row
	logic [CW-1:0] rem_q;      // words still to list

	logic                 acc;
	logic                 full;
	logic                 can_push;
	logic                 push;
	res_t                 push_data;
	res_t                 out_res;
	cell_ctrl_t           ctrl;
	logic [3:0]           in_rating;
	logic [TAG_WIDTH+15:0] in_ext;
	logic [TAG_WIDTH-1:0] in_tag;
	logic [TAG_WIDTH+15:0] head_ext;

	// cell outputs, one per fixed position
	logic [3:0]           cell_rating [TABLE_DEPTH];
	logic [TAG_WIDTH-1:0] cell_tag    [TABLE_DEPTH];
	logic                 cell_ge     [TABLE_DEPTH];

	assign in_rating = s_tdata[3:0];
	assign in_ext    = {{TAG_WIDTH{1'b0}}, s_tdata[19:4]};
	assign in_tag    = in_ext[TAG_WIDTH-1:0];
	assign head_ext  = {16'b0, cell_tag[0]};

	assign full     = cnt_q == CW'(TABLE_DEPTH);
	assign s_tready = (state_q == ST_IDLE) && can_push;
	assign acc      = s_tvalid && s_tready;

	// the row shifts on an insert that fits, rotates while a list drains
	assign ctrl.insert = acc && (s_tuser == CMD_INSERT) && !full;
	assign ctrl.rotate = (state_q == ST_LIST) && can_push;

	// result word for the buffer
	always_comb begin
		push      = 1'b0;
		push_data = '0;
		priority if (acc && (s_tuser == CMD_INSERT)) begin
			push             = 1'b1;
			push_data.status = full ? STATUS_FULL : STATUS_INSERTED;
			push_data.last   = 1'b1;
		end else if (acc && (cnt_q == '0)) begin
			push             = 1'b1;
			push_data.status = STATUS_EMPTY;
			push_data.last   = 1'b1;
		end else if (ctrl.rotate) begin
			push             = 1'b1;
			push_data.status = STATUS_ENTRY;
			push_data.rating = cell_rating[0];
			push_data.tag    = head_ext[15:0];
			push_data.last   = rem_q == CW'(1);
		end else begin
			// nothing to send this cycle
			push = 1'b0;
		end
	end

	// sequencer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
		end else begin
			if (ctrl.insert) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc && (s_tuser == CMD_LIST) && (cnt_q != '0)) begin
						state_q <= ST_LIST;
						rem_q   <= cnt_q;
					end
				end
				ST_LIST: begin
					if (ctrl.rotate) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// row of cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [3:0]           prev_rating;
		logic [TAG_WIDTH-1:0] prev_tag;
		logic                 prev_ge;
		logic [3:0]           next_rating;
		logic [TAG_WIDTH-1:0] next_tag;

		if (i == 0) begin : g_first
			assign prev_rating = '0;
			assign prev_tag    = '0;
			assign prev_ge     = 1'b0;
		end else begin : g_mid
			assign prev_rating = cell_rating[i-1];
			assign prev_tag    = cell_tag[i-1];
			assign prev_ge     = cell_ge[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign next_rating = cell_rating[0];
			assign next_tag    = cell_tag[0];
		end else begin : g_inner
			assign next_rating = cell_rating[i+1];
			assign next_tag    = cell_tag[i+1];
		end

		sit_cell #(
			.IDX       (i),
			.CW        (CW),
			.TAG_WIDTH (TAG_WIDTH)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.cnt         (cnt_q),
			.new_rating  (in_rating),
			.new_tag     (in_tag),
			.prev_rating (prev_rating),
			.prev_tag    (prev_tag),
			.prev_ge     (prev_ge),
			.next_rating (next_rating),
			.next_tag    (next_tag),
			.head_rating (cell_rating[0]),
			.head_tag    (cell_tag[0]),
			.rating      (cell_rating[i]),
			.tag         (cell_tag[i]),
			.ge          (cell_ge[i])
		);
	end

	sit_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.can_push  (can_push),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_data    (out_res)
	);

	assign m_tdata = {4'b0, out_res.tag, out_res.rating};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.last;

	// fill count never passes the depth
	`SIT_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(TABLE_DEPTH), "fill count past depth")
	// no input taken while a list drains
	`SIT_ASSERT_NOW(a_list_blocks, clk, arst_n, state_q == ST_LIST, !s_tready, "input taken during list")
	// an insert that fits grows the table by one
	`SIT_ASSERT_NEXT(a_ins_grow, clk, arst_n, ctrl.insert, cnt_q == $past(cnt_q) + 1'b1, "insert lost")
	// a list leaves the table as it was
	`SIT_ASSERT_NEXT(a_list_keep, clk, arst_n, ctrl.rotate, cnt_q == $past(cnt_q), "list changed count")

endmodule

[design/sit_cell.sv]
// one cell of the sorted row: compare, shift on insert, rotate on list
module sit_cell import sit_pkg::*; #(
	parameter int IDX       = 0,
	parameter int CW        = 5,
	parameter int TAG_WIDTH = 16
) (
	input  logic                 clk,
	input  cell_ctrl_t           ctrl,
	input  logic [CW-1:0]        cnt,
	input  logic [3:0]           new_rating,
	input  logic [TAG_WIDTH-1:0] new_tag,
	input  logic [3:0]           prev_rating,
	input  logic [TAG_WIDTH-1:0] prev_tag,
	input  logic                 prev_ge,
	input  logic [3:0]           next_rating,
	input  logic [TAG_WIDTH-1:0] next_tag,
	input  logic [3:0]           head_rating,
	input  logic [TAG_WIDTH-1:0] head_tag,
	output logic [3:0]           rating,
	output logic [TAG_WIDTH-1:0] tag,
	output logic                 ge
);

	localparam logic [CW:0] IDX_C = (CW+1)'(IDX);

	logic [3:0]           rating_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic                 occ;
	logic                 prev_occ;
	logic                 tail;
	logic                 take_new;

	assign occ      = IDX_C < {1'b0, cnt};
	assign prev_occ = (IDX == 0) || (IDX_C <= {1'b0, cnt});
	assign tail     = (IDX_C + 1'b1) == {1'b0, cnt};
	assign ge       = occ && (rating_q >= new_rating);
	assign take_new = prev_occ && (ge || !occ);

	always_ff @(posedge clk) begin
		if (ctrl.rotate) begin
			if (tail) begin
				rating_q <= head_rating;
				tag_q    <= head_tag;
			end else begin
				rating_q <= next_rating;
				tag_q    <= next_tag;
			end
		end else if (ctrl.insert) begin
			if (prev_ge) begin
				rating_q <= prev_rating;
				tag_q    <= prev_tag;
			end else if (take_new) begin
				rating_q <= new_rating;
				tag_q    <= new_tag;
			end
		end
	end

	assign rating = rating_q;
	assign tag    = tag_q;

endmodule

[design/sit_obuf.sv]
// two-word output buffer between the cell row and the result stream
module sit_obuf import sit_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic can_push,
	output logic m_valid,
	input  logic m_ready,
	output res_t m_data
);

	res_t head_q;
	res_t skid_q;
	logic head_v_q;
	logic skid_v_q;
	logic pop;

	assign pop      = head_v_q && m_ready;
	assign can_push = !skid_v_q;
	assign m_valid  = head_v_q;
	assign m_data   = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			if (head_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				head_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			if (head_v_q) begin
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end
	end

endmodule
